// ----- rtl/rbh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbh_pkg
// Shared types, constants and the de-whitening function of the bind and hop
// receiver.
// ----------------------------------------------------------------------------
package rbh_pkg;

   localparam int unsigned MAX_HOP_CHANNELS = 8;

   localparam logic [7:0] LFSR_SEED    = 8'h6b;
   localparam logic [7:0] LFSR_TAP     = 8'h11;
   localparam logic [7:0] BIND_HDR0    = 8'had;
   localparam logic [7:0] BIND_HDR1    = 8'hc9;
   localparam logic [6:0] BIND_CHANNEL = 7'h4c;
   localparam logic [6:0] HOP_BASE     = 7'h10;
   localparam logic [6:0] HOP_STEP     = 7'h0c;

   localparam logic [39:0] BIND_ADDRESS  = 40'h8f7e6d5c4b;
   localparam logic [3:0]  HOP_COUNT_RST = 4'd4;
   localparam logic [19:0] TIMEOUT_RST   = 20'd5000;

   // position counter saturates here
   localparam logic [4:0] POS_MAX = 5'd31;

   // packet status codes
   localparam logic [1:0] PKT_NONE = 2'd0;
   localparam logic [1:0] PKT_BIND = 2'd1;
   localparam logic [1:0] PKT_DATA = 2'd2;

   // header match codes
   localparam logic [1:0] HDR_NONE  = 2'd0;
   localparam logic [1:0] HDR_FIRST = 2'd1;
   localparam logic [1:0] HDR_BOTH  = 2'd3;

   // register indexes
   localparam logic REG_HOP_COUNT   = 1'b0;
   localparam logic REG_HOP_TIMEOUT = 1'b1;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef struct packed {
      logic        kind;
      logic [7:0]  byte_in;
      logic        last_byte;
      logic [31:0] now_us;
   } req_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic        byte_valid;
      logic [1:0]  packet_status;
      logic [6:0]  rf_channel;
      logic        hopped;
      logic        is_bound;
      logic [39:0] link_address;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  hop_count;
      logic [19:0] hop_timeout_us;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] lfsr;
   } dewhiten_type;

   function automatic dewhiten_type dewhiten(input logic [7:0] lfsr_val,
                                             input logic [7:0] data_val);
      logic [7:0]   l;
      logic [7:0]   d;
      dewhiten_type r;
      l = lfsr_val;
      d = data_val;
      for (int i = 0; i < 8; i++) begin
         if (l[7]) begin
            l    = l ^ LFSR_TAP;
            d[i] = ~d[i];
         end
         l = {l[6:0], 1'b0};
      end
      r.data = d;
      r.lfsr = l;
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/rf_bind_and_hop_receiver_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rf_bind_and_hop_receiver_top
// Receive side of a bind-and-hop radio link: de-whitening, binding and
// channel hopping, one packet byte or poll per transaction.
// ----------------------------------------------------------------------------
// Each transaction is registered at the input, passes through the step logic
// (8-bit de-whitening LFSR, header compares, 32-bit timeout subtract and
// compare, hop index update) and lands in the result register, which raises
// rsp_valid; it waits in the input register while the result register is
// held. One transaction is taken every cycle while the result side keeps up;
// with the result side stalled, two transactions are held and req_ready
// drops. Link state is updated as a transaction moves from the input
// register into the result register.
// Registers: hop_count at byte address 0x0, hop_timeout_us at 0x4.
// ----------------------------------------------------------------------------
module rf_bind_and_hop_receiver_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire rbh_pkg::req_type                req_data,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      rbh_pkg::rsp_type                rsp_data,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rbh_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [rbh_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [rbh_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output      logic                            csr_pready
);

   rbh_pkg::cfg_type cfg;
   rbh_pkg::req_type item_ff;
   rbh_pkg::rsp_type rsp_ff;
   rbh_pkg::rsp_type step_rsp;
   logic             item_valid_ff;
   logic             item_valid_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             advance;

   rbh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // move the held transaction on when the result register is free
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   rbh_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (step_rsp)
   );

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_ready) begin
         item_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/rbh_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbh_csr
// Configuration registers behind the APB-style port: hop count and hop
// timeout.
// ----------------------------------------------------------------------------
module rbh_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [rbh_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [rbh_pkg::CSR_DATA_W-1:0]  pwdata,
   output      logic [rbh_pkg::CSR_DATA_W-1:0]  prdata,
   output      logic                            pready,
   output      rbh_pkg::cfg_type                cfg
);

   logic [3:0]  hop_count_ff;
   logic [3:0]  hop_count_in;
   logic [19:0] timeout_ff;
   logic [19:0] timeout_in;
   logic        wr_en;
   logic        reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   // registers sit on a 4-byte stride
   assign reg_sel = paddr[2];

   always_comb begin
      hop_count_in = hop_count_ff;
      timeout_in   = timeout_ff;
      if (wr_en) begin
         unique case (reg_sel)
            rbh_pkg::REG_HOP_COUNT:   hop_count_in = pwdata[3:0];
            rbh_pkg::REG_HOP_TIMEOUT: timeout_in   = pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_count_ff <= rbh_pkg::HOP_COUNT_RST;
         timeout_ff   <= rbh_pkg::TIMEOUT_RST;
      end else begin
         hop_count_ff <= hop_count_in;
         timeout_ff   <= timeout_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         rbh_pkg::REG_HOP_COUNT:   prdata = {28'd0, hop_count_ff};
         rbh_pkg::REG_HOP_TIMEOUT: prdata = {12'd0, timeout_ff};
         default:                  prdata = '0;
      endcase
   end

   assign cfg.hop_count      = hop_count_ff;
   assign cfg.hop_timeout_us = timeout_ff;

endmodule
`default_nettype wire

// ----- rtl/rbh_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbh_step
// Link state and the single-pass step logic: de-whitening, bind header
// detect, address capture, hop and timeout decisions.
// ----------------------------------------------------------------------------
module rbh_step (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire rbh_pkg::req_type item,
   input  wire rbh_pkg::cfg_type cfg,
   output      rbh_pkg::rsp_type result
);

   logic        bound_ff,    bound_in;
   logic [7:0]  lfsr_ff,     lfsr_in;
   logic [4:0]  pos_ff,      pos_in;
   logic [1:0]  hdr_ff,      hdr_in;
   logic [39:0] capt_ff,     capt_in;
   logic [39:0] addr_ff,     addr_in;
   logic [2:0]  idx_ff,      idx_in;
   logic [31:0] last_hop_ff, last_hop_in;

   rbh_pkg::dewhiten_type dw;
   logic [31:0] elapsed;
   logic        timed_out;
   logic [3:0]  hop_n;
   logic [3:0]  idx_inc;
   logic [2:0]  idx_hop;
   logic        is_bind;
   logic        hopped;
   logic [1:0]  status;

   assign dw        = rbh_pkg::dewhiten(lfsr_ff, item.byte_in);
   assign elapsed   = item.now_us - last_hop_ff;
   assign timed_out = elapsed > {12'd0, cfg.hop_timeout_us};

   // effective channel count, clamped to 1..MAX_HOP_CHANNELS
   always_comb begin
      if (cfg.hop_count > 4'(rbh_pkg::MAX_HOP_CHANNELS)) begin
         hop_n = 4'(rbh_pkg::MAX_HOP_CHANNELS);
      end else if (cfg.hop_count == 4'd0) begin
         hop_n = 4'd1;
      end else begin
         hop_n = cfg.hop_count;
      end
      idx_inc = {1'b0, idx_ff} + 4'd1;
      idx_hop = (idx_inc >= hop_n) ? 3'd0 : idx_inc[2:0];
   end

   always_comb begin
      bound_in    = bound_ff;
      lfsr_in     = lfsr_ff;
      pos_in      = pos_ff;
      hdr_in      = hdr_ff;
      capt_in     = capt_ff;
      addr_in     = addr_ff;
      idx_in      = idx_ff;
      last_hop_in = last_hop_ff;
      hopped      = 1'b0;
      status      = rbh_pkg::PKT_NONE;
      is_bind     = 1'b0;

      if (!item.kind) begin
         if (bound_ff && timed_out) begin
            idx_in      = idx_hop;
            last_hop_in = item.now_us;
            hopped      = 1'b1;
         end
      end else begin
         lfsr_in = dw.lfsr;
         unique case (pos_ff)
            5'd0: begin
               capt_in = '0;
               hdr_in  = (dw.data == rbh_pkg::BIND_HDR0) ? rbh_pkg::HDR_FIRST
                                                          : rbh_pkg::HDR_NONE;
            end
            5'd1: begin
               hdr_in = (hdr_ff[0] && dw.data == rbh_pkg::BIND_HDR1)
                        ? rbh_pkg::HDR_BOTH : rbh_pkg::HDR_NONE;
            end
            5'd2: capt_in[7:0]   = capt_ff[7:0]   | dw.data;
            5'd3: capt_in[15:8]  = capt_ff[15:8]  | dw.data;
            5'd4: capt_in[23:16] = capt_ff[23:16] | dw.data;
            5'd5: capt_in[31:24] = capt_ff[31:24] | dw.data;
            5'd6: capt_in[39:32] = capt_ff[39:32] | dw.data;
            default: ;
         endcase
         if (pos_ff < rbh_pkg::POS_MAX) begin
            pos_in = pos_ff + 5'd1;
         end

         if (item.last_byte) begin
            is_bind = hdr_in[1];
            if (!bound_ff) begin
               if (is_bind) begin
                  status      = rbh_pkg::PKT_BIND;
                  addr_in     = capt_in;
                  bound_in    = 1'b1;
                  idx_in      = 3'd0;
                  last_hop_in = item.now_us;
                  hopped      = 1'b1;
               end
            end else begin
               status = is_bind ? rbh_pkg::PKT_BIND : rbh_pkg::PKT_DATA;
               if (!is_bind || timed_out) begin
                  idx_in      = idx_hop;
                  last_hop_in = item.now_us;
                  hopped      = 1'b1;
               end
            end
            lfsr_in = rbh_pkg::LFSR_SEED;
            pos_in  = '0;
            hdr_in  = rbh_pkg::HDR_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff    <= 1'b0;
         lfsr_ff     <= rbh_pkg::LFSR_SEED;
         pos_ff      <= '0;
         hdr_ff      <= rbh_pkg::HDR_NONE;
         capt_ff     <= '0;
         addr_ff     <= rbh_pkg::BIND_ADDRESS;
         idx_ff      <= '0;
         last_hop_ff <= '0;
      end else if (step_en) begin
         bound_ff    <= bound_in;
         lfsr_ff     <= lfsr_in;
         pos_ff      <= pos_in;
         hdr_ff      <= hdr_in;
         capt_ff     <= capt_in;
         addr_ff     <= addr_in;
         idx_ff      <= idx_in;
         last_hop_ff <= last_hop_in;
      end
   end

   // result reflects the state after this transaction
   always_comb begin
      result.byte_out      = item.kind ? dw.data : 8'd0;
      result.byte_valid    = item.kind;
      result.packet_status = status;
      result.rf_channel    = bound_in
                             ? rbh_pkg::HOP_BASE + {4'd0, addr_in[2:0]}
                               + 7'(idx_in) * rbh_pkg::HOP_STEP
                             : rbh_pkg::BIND_CHANNEL;
      result.hopped        = hopped;
      result.is_bound      = bound_in;
      result.link_address  = addr_in;
   end

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bind and hop receiver. Whitened packets, polls
// and raw noise are pushed through the request channel. Every accepted
// transaction is run through a behavioral copy of the receiver, and each
// result is checked field by field in order. Hop count and timeout registers
// are changed over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import rbh_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned PHASE_ITEMS = 200;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // receiver state as predicted
   logic        rx_bound;
   logic [7:0]  rx_lfsr;
   logic [4:0]  rx_pos;
   logic [1:0]  rx_hdr;
   logic [39:0] rx_capture;
   logic [39:0] rx_link;
   logic [2:0]  rx_hop_idx;
   logic [31:0] rx_last_hop;
   logic [3:0]  cfg_hop_count;
   logic [19:0] cfg_hop_timeout;

   rsp_type     rx_results_due[$];
   logic [7:0]  tx_plain[$];
   logic [7:0]  tx_lfsr;

   logic [31:0] now_us        = 32'hffff_ff00;
   int unsigned time_step_max = 0;
   bit          random_jumps  = 1'b0;
   bit          steady        = 1'b0;
   bit          long_hold_req = 1'b0;
   int unsigned items_offered = 0;
   int unsigned result_count  = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count   = 0;

   rf_bind_and_hop_receiver_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rx_bound        = 1'b0;
      rx_lfsr         = LFSR_SEED;
      rx_pos          = '0;
      rx_hdr          = HDR_NONE;
      rx_capture      = '0;
      rx_link         = BIND_ADDRESS;
      rx_hop_idx      = '0;
      rx_last_hop     = '0;
      cfg_hop_count   = HOP_COUNT_RST;
      cfg_hop_timeout = TIMEOUT_RST;
   end

   // returns {next lfsr state, xor mask for one byte}
   function automatic logic [15:0] lfsr_step(input logic [7:0] seed_state);
      logic [7:0] st;
      logic [7:0] mask;
      st   = seed_state;
      mask = '0;
      for (int i = 0; i < 8; i++) begin
         if (st[7]) begin
            st      = st ^ LFSR_TAP;
            mask[i] = 1'b1;
         end
         st = st << 1;
      end
      return {st, mask};
   endfunction

   task automatic advance_hop(input logic [31:0] stamp);
      logic [3:0] span;
      logic [3:0] nxt;
      span = (cfg_hop_count > MAX_HOP_CHANNELS) ? 4'(MAX_HOP_CHANNELS) : cfg_hop_count;
      if (span == 0) span = 4'd1;
      nxt = {1'b0, rx_hop_idx} + 4'd1;
      if (nxt >= span) nxt = '0;
      rx_hop_idx  = nxt[2:0];
      rx_last_hop = stamp;
   endtask

   task automatic predict_receiver_step(input req_type item);
      rsp_type     r;
      logic [15:0] adv;
      logic [7:0]  b;
      logic        timed_out;
      logic        is_bind;
      r               = '0;
      r.packet_status = PKT_NONE;
      timed_out = (item.now_us - rx_last_hop) > {12'd0, cfg_hop_timeout};
      if (!item.kind) begin
         if (rx_bound && timed_out) begin
            advance_hop(item.now_us);
            r.hopped = 1'b1;
         end
      end else begin
         adv          = lfsr_step(rx_lfsr);
         rx_lfsr      = adv[15:8];
         b            = item.byte_in ^ adv[7:0];
         r.byte_out   = b;
         r.byte_valid = 1'b1;
         if (rx_pos == 0) begin
            rx_capture = '0;
            rx_hdr     = (b == BIND_HDR0) ? HDR_FIRST : HDR_NONE;
         end else if (rx_pos == 1) begin
            rx_hdr = (rx_hdr[0] && b == BIND_HDR1) ? HDR_BOTH : HDR_NONE;
         end else if (rx_pos <= 6) begin
            rx_capture = rx_capture | ({32'd0, b} << (8 * (int'(rx_pos) - 2)));
         end
         if (rx_pos != POS_MAX) rx_pos = rx_pos + 5'd1;
         if (item.last_byte) begin
            is_bind = rx_hdr[1];
            if (!rx_bound) begin
               if (is_bind) begin
                  r.packet_status = PKT_BIND;
                  rx_link         = rx_capture;
                  rx_bound        = 1'b1;
                  rx_hop_idx      = '0;
                  rx_last_hop     = item.now_us;
                  r.hopped        = 1'b1;
               end
            end else begin
               r.packet_status = is_bind ? PKT_BIND : PKT_DATA;
               // a bind packet while bound only hops on timeout
               if (!is_bind || timed_out) begin
                  advance_hop(item.now_us);
                  r.hopped = 1'b1;
               end
            end
            rx_lfsr = LFSR_SEED;
            rx_pos  = '0;
            rx_hdr  = HDR_NONE;
         end
      end
      r.rf_channel = rx_bound ?
                     HOP_BASE + {4'd0, rx_link[2:0]} + HOP_STEP * {4'd0, rx_hop_idx} :
                     BIND_CHANNEL;
      r.is_bound     = rx_bound;
      r.link_address = rx_link;
      rx_results_due.push_back(r);
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic offer_transaction(input logic kind, input logic [7:0] raw,
                                    input logic last);
      req_type     item;
      int unsigned gap;
      if (random_jumps && $urandom_range(0, 39) == 0) now_us = $urandom();
      else now_us = now_us + $urandom_range(0, time_step_max);
      item.kind      = kind;
      item.byte_in   = raw;
      item.last_byte = last;
      item.now_us    = now_us;
      gap = steady ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_receiver_step(item);
      items_offered++;
   endtask

   // whitens and sends the bytes queued in tx_plain as one packet
   task automatic send_packet();
      logic [15:0] adv;
      tx_lfsr = LFSR_SEED;
      for (int k = 0; k < tx_plain.size(); k++) begin
         adv     = lfsr_step(tx_lfsr);
         tx_lfsr = adv[15:8];
         offer_transaction(1'b1, tx_plain[k] ^ adv[7:0], k == tx_plain.size() - 1);
      end
      tx_plain.delete();
   endtask

   task automatic send_poll();
      offer_transaction(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_random_packet(input int unsigned len, input bit bind_header);
      for (int k = 0; k < len; k++) tx_plain.push_back(8'($urandom_range(0, 255)));
      if (bind_header) begin
         tx_plain[0] = BIND_HDR0;
         if (len > 1) tx_plain[1] = BIND_HDR1;
      end else if ($urandom_range(0, 5) == 0) begin
         tx_plain[0] = BIND_HDR0;
      end
      send_packet();
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rx_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic reg_index, input logic [31:0] value);
      settle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_index == REG_HOP_COUNT) cfg_hop_count = value[3:0];
      else cfg_hop_timeout = value[19:0];
   endtask

   // unbound: polls and non-bind packets leave everything alone
   task automatic test_bind_state();
      time_step_max = 0;
      send_poll();
      send_poll();
      tx_plain = '{BIND_HDR0, 8'h00};
      send_packet();
      tx_plain = '{8'h11};
      send_packet();
   endtask

   // short bind packet: missing address bytes read as zero
   task automatic test_binding();
      tx_plain = '{BIND_HDR0, BIND_HDR1, 8'h3d, 8'ha2, 8'h7f};
      send_packet();
   endtask

   task automatic test_data_hops();
      tx_plain = '{8'h55, 8'hff, 8'h00};
      send_packet();
      // exactly at the timeout: no hop, one more microsecond hops across the wrap
      now_us = now_us + TIMEOUT_RST;
      send_poll();
      now_us = now_us + 1;
      send_poll();
      tx_plain = '{BIND_HDR0, BIND_HDR1, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
      send_packet();
      now_us = now_us + TIMEOUT_RST + 1000;
      tx_plain = '{BIND_HDR0, BIND_HDR1};
      send_packet();
   endtask

   task automatic probe_timeout(input logic [31:0] value);
      write_register(REG_HOP_TIMEOUT, value);
      send_random_packet(1, 1'b0);
      now_us = now_us + value[19:0];
      send_poll();
      now_us = now_us + 1;
      send_poll();
   endtask

   task automatic test_hop_settings();
      logic [3:0] counts[5] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9};
      time_step_max = 0;
      foreach (counts[i]) begin
         write_register(REG_HOP_COUNT, {28'd0, counts[i]});
         repeat (9) send_random_packet(1, 1'b0);
      end
      write_register(REG_HOP_COUNT, 32'd3);
      probe_timeout(32'd1);
      probe_timeout(32'd0);
      probe_timeout(32'hfffff);
      probe_timeout(32'd1000000);
   endtask

   // receiver stalls for a long stretch while requests keep coming back to back
   task automatic test_back_pressure();
      write_register(REG_HOP_TIMEOUT, 32'd40);
      time_step_max = 15;
      steady        = 1'b1;
      long_hold_req = 1'b1;
      repeat (12) begin
         send_random_packet($urandom_range(3, 6), 1'b0);
         send_poll();
      end
      steady = 1'b0;
   endtask

   task automatic test_random_traffic();
      int unsigned start;
      int unsigned pick;
      logic [31:0] tmo;
      random_jumps = 1'b1;
      for (int p = 0; p < 5; p++) begin
         case ($urandom_range(0, 5))
            0: tmo = 32'd1;
            1: tmo = 32'd50;
            2: tmo = 32'd5000;
            3: tmo = 32'd1000000;
            4: tmo = 32'hfffff;
            default: tmo = {12'd0, 20'($urandom())};
         endcase
         write_register(REG_HOP_COUNT, 32'($urandom_range(0, 15)));
         write_register(REG_HOP_TIMEOUT, tmo);
         time_step_max = tmo[19:0] / 3 + 2;
         steady        = (p == 2);
         start         = items_offered;
         while (items_offered - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               send_random_packet(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
                                  $urandom_range(1, 8), 1'b0);
            end else if (pick < 62) begin
               send_random_packet($urandom_range(2, 9), 1'b1);
            end else if (pick < 82) begin
               send_poll();
            end else begin
               // noise, then a last byte so later packets start aligned
               repeat ($urandom_range(1, 3))
                  offer_transaction(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)));
               offer_transaction(1'b1, 8'($urandom_range(0, 255)), 1'b1);
            end
         end
      end
      steady       = 1'b0;
      random_jumps = 1'b0;
   endtask

   initial begin : result_drain
      int unsigned hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = steady ? 0 : $urandom_range(0, 7);
         if (long_hold_req) begin
            hold          = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rx_results_due.size() == 0) begin
            report_mismatch($sformatf("transaction %0d arrived with nothing expected",
                                      result_count));
         end else begin
            due = rx_results_due.pop_front();
            if (rsp_data.byte_out !== due.byte_out)
               report_mismatch($sformatf("#%0d byte_out %h, expected %h", result_count,
                                         rsp_data.byte_out, due.byte_out));
            if (rsp_data.byte_valid !== due.byte_valid)
               report_mismatch($sformatf("#%0d byte_valid %b, expected %b", result_count,
                                         rsp_data.byte_valid, due.byte_valid));
            if (rsp_data.packet_status !== due.packet_status)
               report_mismatch($sformatf("#%0d packet_status %0d, expected %0d", result_count,
                                         rsp_data.packet_status, due.packet_status));
            if (rsp_data.rf_channel !== due.rf_channel)
               report_mismatch($sformatf("#%0d rf_channel %h, expected %h", result_count,
                                         rsp_data.rf_channel, due.rf_channel));
            if (rsp_data.hopped !== due.hopped)
               report_mismatch($sformatf("#%0d hopped %b, expected %b", result_count,
                                         rsp_data.hopped, due.hopped));
            if (rsp_data.is_bound !== due.is_bound)
               report_mismatch($sformatf("#%0d is_bound %b, expected %b", result_count,
                                         rsp_data.is_bound, due.is_bound));
            if (rsp_data.link_address !== due.link_address)
               report_mismatch($sformatf("#%0d link_address %h, expected %h", result_count,
                                         rsp_data.link_address, due.link_address));
         end
         result_count++;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_bind_state();
      test_binding();
      test_data_hops();
      test_hop_settings();
      test_back_pressure();
      test_random_traffic();
      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/rbh_pkg.sv
rtl/rbh_csr.sv
rtl/rbh_step.sv
rtl/rf_bind_and_hop_receiver_top.sv
dv/tb_top.sv
